[rtl/edd_pkg.sv]
// shared constants and types for the error diffusion dither unit
// no dependencies; used by error_diffusion_dither_unit
package edd_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int PIXEL_W    = 8;
  localparam int ROW_LEN_W  = 11;
  localparam int THR_W      = 12;
  localparam int DATA_BYTES = 8;

  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 11'd640;
  localparam logic [THR_W-1:0]     THR_RESET     = 12'd2040;

  // register index is byte address bit 2
  typedef enum logic {
    REG_ROW_LENGTH = 1'b0,
    REG_THRESHOLD  = 1'b1
  } reg_idx_t;

endpackage

[rtl/error_diffusion_dither_unit.sv]
// Floyd-Steinberg error diffusion dither, top level
// depends on edd_pkg; holds the below-row error memory and the diffusion datapath
//
// Usage: grey pixels enter one per beat on the s_ channel (s_tdata = pixel,
// s_tuser = frame_start). Each pixel gives one beat on the m_ channel with the
// dot in m_tdata bit 0 and m_tlast set on the last pixel of a row.
// Row length and threshold are written through the APB port while idle:
// address 0 is row_length, address 4 is threshold_x16; reads return them.
// Throughput: one pixel per clock while m_tready stays high. The below-row
// error lives in a one-port write, one-port read memory read at acceptance;
// the carry to the right neighbor closes within the second stage, which sets the rate.
// An accepted pixel is registered in the second stage, then in the output register on m_.
// An output register parts the two sides; while m_tready is low the result
// holds and one further pixel is taken into the second stage, then s_tready drops.
// Reset clears the carries, the column and the channels and sets first-row
// mode; the error memory is not cleared, the first row of a frame ignores it.
module error_diffusion_dither_unit #(
  parameter int MAX_ROW   = 1024,
  parameter int FRAC_BITS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // stream in
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [edd_pkg::PIXEL_W-1:0]      s_tdata,   // [7:0] pixel
  input  logic                             s_tuser,   // [0] frame_start
  // stream out
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [edd_pkg::DATA_BYTES-1:0]   m_tdata,   // [0] dot, [7:1] zero
  output logic                             m_tlast,   // row_end
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [edd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [edd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [edd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int EW = FRAC_BITS + 10;
  localparam int CW = $clog2(MAX_ROW);
  localparam int LW = (CW + 1 > edd_pkg::ROW_LEN_W) ? CW + 1 : edd_pkg::ROW_LEN_W;
  localparam logic signed [EW+1:0] ERR_HI = (EW+2)'((1 << (EW - 1)) - 1);
  localparam logic signed [EW+1:0] ERR_LO = -(EW+2)'(1 << (EW - 1));
  localparam logic signed [EW:0]   FULL_SCALE = (EW+1)'(255 << FRAC_BITS);

  function automatic logic signed [EW-1:0] clamp_err(input logic signed [EW+1:0] v);
    logic signed [EW-1:0] r;
    if (v > ERR_HI) begin
      r = EW'(ERR_HI);
    end else if (v < ERR_LO) begin
      r = EW'(ERR_LO);
    end else begin
      r = EW'(v);
    end
    return r;
  endfunction

  // configuration registers
  logic [edd_pkg::ROW_LEN_W-1:0] row_length;
  logic [edd_pkg::THR_W-1:0]     threshold_x16;
  logic                          cfg_we;
  edd_pkg::reg_idx_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = edd_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length    <= edd_pkg::ROW_LEN_RESET;
      threshold_x16 <= edd_pkg::THR_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        edd_pkg::REG_ROW_LENGTH: row_length    <= pwdata[edd_pkg::ROW_LEN_W-1:0];
        edd_pkg::REG_THRESHOLD:  threshold_x16 <= pwdata[edd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      edd_pkg::REG_ROW_LENGTH: prdata = edd_pkg::CFG_DATA_W'(row_length);
      edd_pkg::REG_THRESHOLD:  prdata = edd_pkg::CFG_DATA_W'(threshold_x16);
      default:                 prdata = '0;
    endcase
  end

  // effective row length minus one
  logic [LW-1:0] rl_ext;
  logic [CW-1:0] len_m1;

  assign rl_ext = LW'(row_length);
  always_comb begin
    if (row_length == '0) begin
      len_m1 = '0;
    end else if (rl_ext > LW'(MAX_ROW)) begin
      len_m1 = CW'(MAX_ROW - 1);
    end else begin
      len_m1 = CW'(rl_ext - LW'(1));
    end
  end

  // handshake
  logic s1_valid;
  logic fire;
  logic accept;

  assign fire     = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || fire;
  assign accept   = s_tvalid && s_tready;

  // front end: column and first-row tracking at acceptance
  logic [CW-1:0] col;
  logic          first_row;
  logic [CW-1:0] c_in;
  logic          fr_in;
  logic          last_in;

  assign c_in    = s_tuser ? '0 : col;
  assign fr_in   = s_tuser ? 1'b1 : first_row;
  assign last_in = c_in >= len_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      first_row <= 1'b1;
    end else if (accept) begin
      col       <= last_in ? '0 : c_in + CW'(1);
      first_row <= last_in ? 1'b0 : fr_in;
    end
  end

  // second stage item
  logic [edd_pkg::PIXEL_W-1:0] s1_pix;
  logic                        s1_fs;
  logic                        s1_fr;
  logic                        s1_last;
  logic [CW-1:0]               s1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= s_tdata;
      s1_fs   <= s_tuser;
      s1_fr   <= fr_in;
      s1_last <= last_in;
      s1_col  <= c_in;
    end
  end

  // below-row error memory
  logic signed [EW-1:0] err_mem [MAX_ROW];
  logic signed [EW-1:0] ram_q;
  logic                 wr_en;
  logic [CW-1:0]        wr_addr;
  logic signed [EW-1:0] wr_data;
  logic                 fwd_hit;
  logic signed [EW-1:0] fwd_data;
  logic signed [EW-1:0] mem_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      err_mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      ram_q <= err_mem[c_in];
    end
  end

  // a write landing on the entry being read at the same edge is forwarded
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= wr_en && (wr_addr == c_in);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= wr_data;
    end
  end

  assign mem_q = fwd_hit ? fwd_data : ram_q;

  // diffusion state
  logic signed [EW-1:0] right_carry;
  logic signed [EW-1:0] pend_bl;
  logic signed [EW-1:0] pend_b;
  logic signed [EW-1:0] rc_eff;
  logic signed [EW-1:0] pbl_eff;
  logic signed [EW-1:0] pb_eff;

  assign rc_eff  = s1_fs ? '0 : right_carry;
  assign pbl_eff = s1_fs ? '0 : pend_bl;
  assign pb_eff  = s1_fs ? '0 : pend_b;

  // datapath
  logic signed [EW+1:0] base;
  logic signed [EW+1:0] below_term;
  logic signed [EW-1:0] value;
  logic signed [EW+4:0] cmp_l;
  logic signed [EW+4:0] cmp_r;
  logic                 dot;
  logic signed [EW:0]   err;
  logic signed [EW+3:0] ex;
  logic signed [EW+3:0] e3;
  logic signed [EW+3:0] e5;
  logic signed [EW+3:0] e7;
  logic signed [EW-1:0] w1;
  logic signed [EW-1:0] w3;
  logic signed [EW-1:0] w5;
  logic signed [EW-1:0] w7;
  logic signed [EW-1:0] new_pbl;
  logic signed [EW-1:0] left_data;

  assign base       = $signed((EW+2)'({s1_pix, {FRAC_BITS{1'b0}}}));
  assign below_term = s1_fr ? '0 : (EW+2)'(mem_q);
  assign value      = clamp_err(base + (EW+2)'(rc_eff) + below_term);

  assign cmp_l = (EW+5)'(value) <<< 4;
  assign cmp_r = $signed((EW+5)'({threshold_x16, {FRAC_BITS{1'b0}}}));
  assign dot   = cmp_l > cmp_r;
  assign err   = dot ? (EW+1)'(value) - FULL_SCALE : (EW+1)'(value);

  // weighted terms, floored by the arithmetic shift
  assign ex = (EW+4)'(err);
  assign e3 = (ex <<< 1) + ex;
  assign e5 = (ex <<< 2) + ex;
  assign e7 = (ex <<< 3) - ex;
  assign w1 = EW'(ex >>> 4);
  assign w3 = EW'(e3 >>> 4);
  assign w5 = EW'(e5 >>> 4);
  assign w7 = EW'(e7 >>> 4);

  assign new_pbl   = clamp_err((EW+2)'(pb_eff) + (EW+2)'(w5));
  assign left_data = clamp_err((EW+2)'(pbl_eff) + (EW+2)'(w3));

  always_ff @(posedge clk) begin
    if (rst) begin
      right_carry <= '0;
      pend_bl     <= '0;
      pend_b      <= '0;
    end else if (fire) begin
      if (s1_last) begin
        right_carry <= '0;
        pend_bl     <= '0;
        pend_b      <= '0;
      end else begin
        right_carry <= w7;
        pend_bl     <= new_pbl;
        pend_b      <= w1;
      end
    end
  end

  // memory writes: below-left every pixel past the first column; at row end the
  // finished below entry too, held in dwr_pend until the port is free
  logic                 main_we;
  logic [CW-1:0]        main_addr;
  logic signed [EW-1:0] main_data;
  logic                 dwr_set;
  logic                 dwr_pend;
  logic [CW-1:0]        dwr_addr;
  logic signed [EW-1:0] dwr_data;

  assign main_we   = fire && ((s1_col != '0) || s1_last);
  assign main_addr = (s1_col == '0) ? '0 : s1_col - CW'(1);
  assign main_data = (s1_col == '0) ? new_pbl : left_data;
  assign dwr_set   = fire && s1_last && (s1_col != '0);

  assign wr_en   = main_we || dwr_pend;
  assign wr_addr = main_we ? main_addr : dwr_addr;
  assign wr_data = main_we ? main_data : dwr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      dwr_pend <= 1'b0;
    end else if (dwr_set) begin
      dwr_pend <= 1'b1;
    end else if (!main_we) begin
      dwr_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dwr_set) begin
      dwr_addr <= s1_col;
      dwr_data <= new_pbl;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= edd_pkg::DATA_BYTES'(dot);
      m_tlast <= s1_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= CW'(MAX_ROW - 1))
    else $error("column beyond row memory");

  a_fire_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("stage two fired without output beat");

  a_dwr_drain: assert property (@(posedge clk) disable iff (rst)
    dwr_pend && !main_we |=> !dwr_pend)
    else $error("deferred row-end write not drained");

  a_row_end_first: assert property (@(posedge clk) disable iff (rst)
    accept && last_in |=> !first_row)
    else $error("first-row mode kept after row end");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !s1_valid && !m_tvalid && !dwr_pend)
    else $error("pipeline not empty after reset");
`endif

endmodule
